>>> src/dqks_pkg.sv
// Shared types and constants for the deque with key search.
package dqks_pkg;

  localparam int ID_W    = 16;
  localparam int PRICE_W = 32;
  localparam int COUNT_W = 5;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SEARCH     = 3'd4,
    OP_UPDATE     = 3'd5,
    OP_COUNT      = 3'd6,
    OP_MAX        = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

>>> src/dqks_store.sv
// Entry storage: id and price arrays with one write port and one registered read port.
module dqks_store #(
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [dqks_pkg::ID_W-1:0]    wkey,
  input  logic [dqks_pkg::PRICE_W-1:0] wprice,
  input  logic [AW-1:0]                raddr,
  output logic [dqks_pkg::ID_W-1:0]    rkey,
  output logic [dqks_pkg::PRICE_W-1:0] rprice
);
  import dqks_pkg::*;

  logic [ID_W-1:0]    key_mem   [DEPTH];
  logic [PRICE_W-1:0] price_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr]   <= wkey;
      price_mem[waddr] <= wprice;
    end
    rkey   <= key_mem[raddr];
    rprice <= price_mem[raddr];
  end

endmodule

>>> src/deque_with_key_search_unit.sv
// Top level of the bounded deque of (id, price) entries with key and maximum search.
// Pushes, pops and count go straight to the done state, which loads the result and raises out_valid.
// Search, update and max read one entry per cycle from the front through the registered
// store port, walking at most DEPTH entries; a new transaction is taken only back in idle,
// and a result that is not taken holds off the next one.
// Synchronous active-high reset empties the queue; stored entries are not cleared.
module deque_with_key_search_unit #(
  parameter int DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  dqks_pkg::op_t                op,
  input  logic [dqks_pkg::ID_W-1:0]    item_id,
  input  logic [dqks_pkg::PRICE_W-1:0] item_price,
  output logic                         out_valid,
  input  logic                         out_ready,
  output dqks_pkg::status_t            status,
  output logic [dqks_pkg::ID_W-1:0]    found_id,
  output logic [dqks_pkg::PRICE_W-1:0] found_price,
  output logic [dqks_pkg::COUNT_W-1:0] entry_count
);
  import dqks_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = ((AW > CW) ? AW : CW) + 1;
  localparam int XW = (CW > COUNT_W) ? CW : COUNT_W;

  state_t state, state_next;

  logic [AW-1:0] front;
  logic [CW-1:0] count;
  op_t           op_r;
  logic [ID_W-1:0]    key_r;
  logic [PRICE_W-1:0] price_r;

  logic [CW-1:0] pos;
  logic [AW-1:0] slot;
  logic          cmp_valid;
  logic          cmp_last;
  logic [AW-1:0] cmp_slot;

  logic               best_valid;
  logic [ID_W-1:0]    best_id;
  logic [PRICE_W-1:0] best_price;

  status_t            res_status;
  logic [ID_W-1:0]    res_id;
  logic [PRICE_W-1:0] res_price;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [ID_W-1:0]    mem_wkey;
  logic [PRICE_W-1:0] mem_wprice;
  logic [ID_W-1:0]    rd_key;
  logic [PRICE_W-1:0] rd_price;

  logic          full, empty, issue, hit, take, needs_scan, out_free;
  logic [AW-1:0] front_inc, front_dec, slot_inc, back_slot;
  logic [SW-1:0] back_sum;
  logic [XW-1:0] count_ext;

  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign front_inc = (front == AW'(DEPTH - 1)) ? '0 : front + 1'b1;
  assign front_dec = (front == '0) ? AW'(DEPTH - 1) : front - 1'b1;
  assign slot_inc  = (slot == AW'(DEPTH - 1)) ? '0 : slot + 1'b1;
  assign back_sum  = SW'(front) + SW'(count);
  assign back_slot = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);
  assign count_ext = XW'(count);
  assign issue     = (pos != count);
  // Key equality for search and update; the price order for max is a separate comparator (take).
  assign hit       = (op_r != OP_MAX) && (rd_key == key_r);
  assign take      = !best_valid || (rd_price > best_price);
  assign needs_scan = (op == OP_SEARCH || op == OP_UPDATE || op == OP_MAX) && !empty;
  assign out_free  = !out_valid || out_ready;

  dqks_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wkey   (mem_wkey),
    .wprice (mem_wprice),
    .raddr  (slot),
    .rkey   (rd_key),
    .rprice (rd_price)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) begin
        state_next = needs_scan ? S_SCAN : S_DONE;
      end
      S_SCAN: if (cmp_valid && (hit || cmp_last)) begin
        state_next = S_DONE;
      end
      S_DONE: if (out_free) begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state == S_IDLE);
    mem_we     = 1'b0;
    mem_waddr  = back_slot;
    mem_wkey   = item_id;
    mem_wprice = item_price;
    unique case (state)
      S_IDLE: begin
        if (in_valid && !full && (op == OP_PUSH_BACK || op == OP_PUSH_FRONT)) begin
          mem_we    = 1'b1;
          mem_waddr = (op == OP_PUSH_BACK) ? back_slot : front_dec;
        end
      end
      S_SCAN: begin
        if (cmp_valid && hit && op_r == OP_UPDATE) begin
          mem_we     = 1'b1;
          mem_waddr  = cmp_slot;
          mem_wkey   = key_r;
          mem_wprice = price_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      count     <= '0;
      out_valid <= 1'b0;
      cmp_valid <= 1'b0;
    end else begin
      state <= state_next;
      // The result register is reloaded from the done state, which sets out_valid itself.
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: if (in_valid) begin
          op_r       <= op;
          key_r      <= item_id;
          price_r    <= item_price;
          res_status <= ST_OK;
          res_id     <= '0;
          res_price  <= '0;
          pos        <= '0;
          slot       <= front;
          cmp_valid  <= 1'b0;
          best_valid <= 1'b0;
          case (op) inside
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
              if (full) begin
                res_status <= ST_FULL;
              end else begin
                count <= count + 1'b1;
                if (op == OP_PUSH_FRONT) begin
                  front <= front_dec;
                end
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (empty) begin
                res_status <= ST_MISS;
              end else begin
                count <= count - 1'b1;
                if (op == OP_POP_FRONT) begin
                  front <= front_inc;
                end
              end
            end
            OP_SEARCH, OP_UPDATE, OP_MAX: begin
              if (empty) begin
                res_status <= ST_MISS;
              end
            end
            default: ;
          endcase
        end
        S_SCAN: begin
          // Reads are issued one slot ahead of the compare, since the store's data is registered.
          if (issue) begin
            cmp_valid <= 1'b1;
            cmp_slot  <= slot;
            cmp_last  <= (pos == count - 1'b1);
            pos       <= pos + 1'b1;
            slot      <= slot_inc;
          end else begin
            cmp_valid <= 1'b0;
          end
          if (cmp_valid) begin
            if (op_r == OP_MAX) begin
              if (take) begin
                best_valid <= 1'b1;
                best_id    <= rd_key;
                best_price <= rd_price;
              end
              if (cmp_last) begin
                res_id    <= take ? rd_key : best_id;
                res_price <= take ? rd_price : best_price;
              end
            end else if (hit) begin
              res_id    <= rd_key;
              res_price <= (op_r == OP_UPDATE) ? price_r : rd_price;
            end else if (cmp_last) begin
              res_status <= ST_MISS;
            end
          end
        end
        S_DONE: if (out_free) begin
          out_valid   <= 1'b1;
          status      <= res_status;
          found_id    <= res_id;
          found_price <= res_price;
          entry_count <= count_ext[COUNT_W-1:0];
        end
        default: ;
      endcase
    end
  end

endmodule

>>> src/dqks_checker.sv
// Port-level checker for the deque unit and its bind to the top level.
module dqks_checker #(
  parameter int DEPTH = 16
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input dqks_pkg::op_t                op,
  input logic [dqks_pkg::ID_W-1:0]    item_id,
  input logic [dqks_pkg::PRICE_W-1:0] item_price,
  input logic                         out_valid,
  input logic                         out_ready,
  input dqks_pkg::status_t            status,
  input logic [dqks_pkg::ID_W-1:0]    found_id,
  input logic [dqks_pkg::PRICE_W-1:0] found_price,
  input logic [dqks_pkg::COUNT_W-1:0] entry_count
);
  import dqks_pkg::*;

  // A result waiting to be taken keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(found_id)
      && $stable(found_price) && $stable(entry_count))
    else $error("result changed while stalled");

  // A dropped push only happens when the queue holds DEPTH entries.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> (DEPTH > 31) || (entry_count == 5'(DEPTH)))
    else $error("full status with a count below capacity");

  // A dropped push or a miss carries no entry.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL || status == ST_MISS) |-> found_id == '0 && found_price == '0)
    else $error("nonzero entry on a failed transaction");

  // The count never exceeds the capacity.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (DEPTH > 31) || (entry_count <= 5'(DEPTH)))
    else $error("entry count above capacity");

  // No result appears in the first cycle after reset is released.
  a_reset_quiet: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("result present right after reset");

endmodule

bind deque_with_key_search_unit dqks_checker #(.DEPTH(DEPTH)) u_dqks_checker (.*);

>>> test/deque_with_key_search_unit_tb.sv
// Self-checking testbench for the deque with key search, with its own prediction of every result.
`timescale 1ns / 100ps

module deque_with_key_search_unit_tb;
  import dqks_pkg::*;

  localparam int QDEPTH    = 16;
  localparam int RAND_ITEMS = 830;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    status_t               st;
    logic [ID_W-1:0]       id;
    logic [PRICE_W-1:0]    price;
    logic [COUNT_W-1:0]    count;
  } deque_result_t;

  typedef enum {MODE_FILL, MODE_MIX, MODE_DRAIN} traffic_mode_t;

  // Keeps a shadow copy of the deque and the results it owes.
  class deque_scoreboard;
    logic [ID_W-1:0]    keys [QDEPTH];
    logic [PRICE_W-1:0] prices [QDEPTH];
    int unsigned        head;
    int unsigned        held;
    deque_result_t      owed [$];
    int                 errors;
    int                 n_inputs;
    int                 n_results;
    int                 full_drops;
    int                 misses;

    function void note_input(op_t o, logic [ID_W-1:0] id, logic [PRICE_W-1:0] pr);
      deque_result_t r;
      int unsigned   s;
      int unsigned   best;
      bit            hit;
      r.st = ST_OK;
      r.id = '0;
      r.price = '0;
      hit = 1'b0;
      n_inputs++;
      case (o) inside
        OP_PUSH_BACK, OP_PUSH_FRONT: begin
          if (held >= QDEPTH) begin
            r.st = ST_FULL;
          end else begin
            if (o == OP_PUSH_BACK) begin
              s = (head + held) % QDEPTH;
            end else begin
              head = (head + QDEPTH - 1) % QDEPTH;
              s = head;
            end
            keys[s] = id;
            prices[s] = pr;
            held++;
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          if (held == 0) begin
            r.st = ST_MISS;
          end else begin
            if (o == OP_POP_FRONT) head = (head + 1) % QDEPTH;
            held--;
          end
        end
        OP_SEARCH, OP_UPDATE: begin
          for (int i = 0; i < held && !hit; i++) begin
            s = (head + i) % QDEPTH;
            if (keys[s] == id) hit = 1'b1;
          end
          if (!hit) begin
            r.st = ST_MISS;
          end else begin
            if (o == OP_UPDATE) prices[s] = pr;
            r.id = keys[s];
            r.price = prices[s];
          end
        end
        OP_COUNT: begin
        end
        default: begin
          if (held == 0) begin
            r.st = ST_MISS;
          end else begin
            best = head;
            for (int i = 1; i < held; i++) begin
              s = (head + i) % QDEPTH;
              // Strictly greater, so the first of equal prices from the front stays.
              if (prices[s] > prices[best]) best = s;
            end
            r.id = keys[best];
            r.price = prices[best];
          end
        end
      endcase
      if (r.st == ST_FULL) full_drops++;
      if (r.st == ST_MISS) misses++;
      r.count = COUNT_W'(held);
      owed.push_back(r);
    endfunction

    function void check_result(status_t st, logic [ID_W-1:0] id, logic [PRICE_W-1:0] pr,
                               logic [COUNT_W-1:0] cnt);
      deque_result_t e;
      n_results++;
      if (owed.size() == 0) begin
        $error("result with no transaction waiting: status %0d id %h price %h count %0d",
               st, id, pr, cnt);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (st !== e.st) begin
        $error("status: expected %0d, actual %0d", e.st, st);
        errors++;
      end
      if (id !== e.id) begin
        $error("found_id: expected %h, actual %h", e.id, id);
        errors++;
      end
      if (pr !== e.price) begin
        $error("found_price: expected %h, actual %h", e.price, pr);
        errors++;
      end
      if (cnt !== e.count) begin
        $error("entry_count: expected %0d, actual %0d", e.count, cnt);
        errors++;
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  op_t                  op = OP_COUNT;
  logic [ID_W-1:0]      item_id = '0;
  logic [PRICE_W-1:0]   item_price = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  status_t              status;
  logic [ID_W-1:0]      found_id;
  logic [PRICE_W-1:0]   found_price;
  logic [COUNT_W-1:0]   entry_count;

  deque_scoreboard      board = new();
  bit                   tx_idle = 1'b1;
  bit                   rx_idle = 1'b1;
  bit                   long_hold_req = 1'b0;
  int                   cycle_count = 0;
  logic [ID_W-1:0]      key_pool [6];

  deque_with_key_search_unit #(.DEPTH(QDEPTH)) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .item_id     (item_id),
    .item_price  (item_price),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .found_id    (found_id),
    .found_price (found_price),
    .entry_count (entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offers one transaction and returns at the edge that accepts it, with valid still high.
  task automatic send_item(input op_t o, input logic [ID_W-1:0] id,
                           input logic [PRICE_W-1:0] pr);
    int gap;
    gap = 0;
    if (tx_idle && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    item_id <= id;
    item_price <= pr;
    do @(posedge clk); while (!in_ready);
    board.note_input(o, id, pr);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  function automatic logic [ID_W-1:0] rand_id();
    case ($urandom_range(0, 9))
      7: return $urandom_range(0, 1) ? {ID_W{1'b1}} : {ID_W{1'b0}};
      8, 9: return ID_W'($urandom_range(0, 65535));
      default: return key_pool[$urandom_range(0, 5)];
    endcase
  endfunction

  // Small prices show up often so that ties in the maximum search are common.
  function automatic logic [PRICE_W-1:0] rand_price();
    case ($urandom_range(0, 7))
      0: return {PRICE_W{1'b1}};
      1: return '0;
      2, 3: return PRICE_W'($urandom_range(1, 4));
      default: return $urandom;
    endcase
  endfunction

  function automatic op_t pick_op(traffic_mode_t m);
    int r;
    r = $urandom_range(0, 99);
    if (m == MODE_MIX) return op_t'($urandom_range(0, 7));
    if (m == MODE_FILL) begin
      if (r < 30) return OP_PUSH_BACK;
      if (r < 60) return OP_PUSH_FRONT;
      if (r < 65) return OP_POP_FRONT;
      if (r < 70) return OP_POP_BACK;
    end else begin
      if (r < 5)  return OP_PUSH_BACK;
      if (r < 10) return OP_PUSH_FRONT;
      if (r < 38) return OP_POP_FRONT;
      if (r < 65) return OP_POP_BACK;
    end
    if (r < 80) return OP_SEARCH;
    if (r < 88) return OP_UPDATE;
    if (r < 92) return OP_COUNT;
    return OP_MAX;
  endfunction

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && out_ready)
        board.check_result(status, found_id, found_price, entry_count);
      if (long_hold_req) begin
        stall_left = 250;
        long_hold_req = 1'b0;
      end else if (stall_left == 0 && rx_idle && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 18);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    traffic_mode_t mode;
    op_t           o;
    mode = MODE_FILL;
    foreach (key_pool[k]) key_pool[k] = ID_W'($urandom_range(0, 65535));
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Everything that can miss on an empty queue, then ties, duplicate keys and extremes.
    send_item(OP_POP_FRONT, '0, '0);
    send_item(OP_POP_BACK, '0, '0);
    send_item(OP_SEARCH, '0, '0);
    send_item(OP_UPDATE, 16'hffff, 32'h1);
    send_item(OP_MAX, '0, '0);
    send_item(OP_COUNT, '0, '0);
    send_item(OP_PUSH_BACK, 16'h0000, 32'hffff_ffff);
    send_item(OP_PUSH_FRONT, 16'hffff, 32'h0000_0000);
    send_item(OP_PUSH_BACK, 16'hffff, 32'hffff_ffff);
    send_item(OP_MAX, '0, '0);
    send_item(OP_PUSH_FRONT, 16'h0000, 32'h7);
    send_item(OP_SEARCH, 16'h0000, '0);
    send_item(OP_UPDATE, 16'h0000, 32'hffff_ffff);
    send_item(OP_MAX, '0, '0);
    send_item(OP_SEARCH, 16'h0abc, '0);
    send_item(OP_UPDATE, 16'h0abc, 32'h55aa_55aa);
    send_item(OP_POP_BACK, '0, '0);
    send_item(OP_POP_FRONT, '0, '0);
    send_item(OP_PUSH_BACK, 16'h5a5a, 32'ha5a5_a5a5);
    send_item(OP_PUSH_FRONT, 16'ha5a5, 32'h5a5a_5a5a);
    send_item(OP_COUNT, '0, '0);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 60 == 0) begin
        // The first stretch fills the queue so that full pushes are hit early.
        if (n > 0) mode = traffic_mode_t'($urandom_range(0, 2));
        foreach (key_pool[k]) key_pool[k] = ID_W'($urandom_range(0, 65535));
      end
      if (n == 200) long_hold_req = 1'b1;
      if (n == 400 || n == 600) wait_drained();
      if (n == RAND_ITEMS - 150) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end
      o = pick_op(mode);
      send_item(o, rand_id(), rand_price());
    end

    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Ran %0d transactions and checked %0d results, with %0d pushes to a full queue",
             board.n_inputs, board.n_results, board.full_drops);
    $display("and %0d on an empty queue or with no matching id.", board.misses);
    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
src/dqks_pkg.sv
src/dqks_store.sv
src/deque_with_key_search_unit.sv
src/dqks_checker.sv
test/deque_with_key_search_unit_tb.sv
